// ===== sv/ple_pkg.sv =====
// Shared types, codes and sizes for the positional list engine.
package ple_pkg;

	// List size and the index and count widths that follow from it.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the item and result formats.
	localparam int CMD_W   = 2;
	localparam int POS_W   = 5;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int FIDX_W  = 4;
	localparam int LEN_W   = 5;

	// Width used to compare positions against cell indexes and the count.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Stream data widths, rounded up to whole bytes.
	localparam int IN_BITS   = CMD_W + POS_W + WORD_W;
	localparam int OUT_BITS  = STAT_W + WORD_W + FIDX_W + LEN_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_READ   = 2'd3
	} ple_op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BADPOS  = 2'd2,
		ST_MISSING = 2'd3
	} ple_status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_OUT  = 3'b100
	} ple_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ple_ctl_t;

endpackage

// ===== sv/ple_ctrl.sv =====
// Controller state machine that sequences one list operation at a time.
module ple_ctrl
	import ple_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output ple_ctl_t ctl
);

	ple_state_t state_q;
	ple_state_t state_d;

	// Next state: take an item, run it, then hold the result until the transfer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (m_tready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Handshake and datapath commands.
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign ctl.load = (state_q == S_IDLE) && s_tvalid;
	assign ctl.exec = (state_q == S_EXEC);

endmodule

// ===== sv/ple_dpath.sv =====
// Datapath: the row of list cells, the count, and the result registers.
module ple_dpath
	import ple_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ple_ctl_t                 ctl,
	input  logic [CMD_W-1:0]         command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] value,
	output logic [STAT_W-1:0]        status,
	output logic signed [WORD_W-1:0] data_out,
	output logic [FIDX_W-1:0]        found_index,
	output logic [LEN_W-1:0]         length
);

	// Operation registers, loaded on the input transfer.
	ple_op_t             op_q;
	logic [POS_W-1:0]    pos_q;
	logic [WORD_W-1:0]   val_q;

	// List state.
	logic [WORD_W-1:0]   cells_q [CAPACITY];
	logic [CNT_W-1:0]    occ_q;

	// Result registers, written in the execute cycle.
	ple_status_t         stat_q;
	logic [WORD_W-1:0]   data_q;
	logic [CAPACITY-1:0] hit_q;
	logic                srch_q;

	logic [CMP_W-1:0]    pos_x;
	logic [CMP_W-1:0]    occ_x;
	logic                is_full;
	logic                ins_ok;
	logic                del_ok;
	logic                in_range;
	logic [WORD_W-1:0]   sel_word;
	logic [CAPACITY-1:0] hit_d;
	logic [IDX_W-1:0]    fidx;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= ple_op_t'(command);
			pos_q <= position;
			val_q <= value;
		end
	end

	// Range checks against the live count.
	assign pos_x    = CMP_W'(pos_q);
	assign occ_x    = CMP_W'(occ_q);
	assign is_full  = (occ_x >= CMP_W'(CAPACITY));
	assign in_range = (pos_x < occ_x);
	assign ins_ok   = ctl.exec && (op_q == CMD_INSERT) && !is_full && (pos_x <= occ_x);
	assign del_ok   = ctl.exec && (op_q == CMD_DELETE) && in_range;
	assign sel_word = cells_q[pos_x[IDX_W-1:0]];

	// Each cell compares against the search word in parallel.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_d[i] = (cells_q[i] == val_q) && (CMP_W'(i) < occ_x);
		end
	end

	// Cells above the position take their lower neighbor on insert; cells from it up take their upper one on delete.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ins_ok) begin
				if (CMP_W'(g) == pos_x) begin
					cells_q[g] <= val_q;
				end else if (CMP_W'(g) > pos_x) begin
					cells_q[g] <= cells_q[(g > 0) ? g - 1 : 0];
				end
			end else if (del_ok) begin
				if ((CMP_W'(g) >= pos_x) && (g < CAPACITY - 1)) begin
					cells_q[g] <= cells_q[(g < CAPACITY - 1) ? g + 1 : g];
				end
			end
		end
	end

	// Live count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ins_ok) begin
			occ_q <= occ_q + CNT_W'(1);
		end else if (del_ok) begin
			occ_q <= occ_q - CNT_W'(1);
		end
	end

	// Status, word and match vector of the operation.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			hit_q  <= hit_d;
			srch_q <= (op_q == CMD_SEARCH);
			case (op_q)
				CMD_INSERT: begin
					data_q <= '0;
					if (is_full) begin
						stat_q <= ST_FULL;
					end else if (pos_x > occ_x) begin
						stat_q <= ST_BADPOS;
					end else begin
						stat_q <= ST_OK;
					end
				end
				CMD_DELETE, CMD_READ: begin
					if (in_range) begin
						stat_q <= ST_OK;
						data_q <= sel_word;
					end else begin
						stat_q <= ST_BADPOS;
						data_q <= '0;
					end
				end
				CMD_SEARCH: begin
					data_q <= '0;
					stat_q <= (hit_d != '0) ? ST_OK : ST_MISSING;
				end
				default: begin
					data_q <= '0;
					stat_q <= ST_BADPOS;
				end
			endcase
		end
	end

	// Lowest matching cell wins.
	always_comb begin
		fidx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit_q[i]) fidx = IDX_W'(i);
		end
	end

	assign status      = stat_q;
	assign data_out    = data_q;
	assign found_index = srch_q ? FIDX_W'(fidx) : '0;
	assign length      = LEN_W'(occ_q);

endmodule

// ===== sv/positional_list_engine_unit.sv =====
// Top level of the positional list engine: ordered list with insert, delete, search, read.
//
//   channel   direction  carries
//   s_axis    in         command, position, value
//   m_axis    out        status, data_out, found_index, length
//
// Each item passes through the input transfer, the execute state in the
// cell row, and the output transfer; a stall on m_axis extends the last step.
// The controller takes a new item only after the previous result transfer.
// Reset empties the list; cell contents are not cleared.
module positional_list_engine_unit
	import ple_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// command [1:0], position [6:2], value [38:7], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// status [1:0], data_out [33:2], found_index [37:34], length [42:38], zero fill above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	ple_ctl_t                 ctl;
	logic [STAT_W-1:0]        status;
	logic signed [WORD_W-1:0] data_out;
	logic [FIDX_W-1:0]        found_index;
	logic [LEN_W-1:0]         length;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.ctl      (ctl)
	);

	ple_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.command     (s_axis_tdata[CMD_W-1:0]),
		.position    (s_axis_tdata[CMD_W +: POS_W]),
		.value       (s_axis_tdata[CMD_W + POS_W +: WORD_W]),
		.status      (status),
		.data_out    (data_out),
		.found_index (found_index),
		.length      (length)
	);

	// Result fields packed from the lowest bit up.
	assign m_axis_tdata = OUT_TDATA_W'({length, found_index, data_out, status});

endmodule
